### rtl/core/lpbe_pkg.sv
`default_nettype none
package lpbe_pkg;

  localparam int unsigned MaxPixelsDefault = 1024;
  localparam int unsigned CountWidth = 11;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [3:0] {
    KIND_SET        = 4'd0,
    KIND_BLEND      = 4'd1,
    KIND_MAX        = 4'd2,
    KIND_ADD        = 4'd3,
    KIND_READ       = 4'd4,
    KIND_COPY       = 4'd5,
    KIND_ROT_UP     = 4'd6,
    KIND_ROT_DOWN   = 4'd7,
    KIND_SHIFT_UP   = 4'd8,
    KIND_SHIFT_DOWN = 4'd9,
    KIND_FADE_SUB   = 4'd10,
    KIND_FADE_MUL   = 4'd11,
    KIND_FILL       = 4'd12,
    KIND_FILL_MAX   = 4'd13,
    KIND_AVERAGE    = 4'd14,
    KIND_NONE       = 4'd15
  } kind_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] pixel;
    logic [15:0] second_pixel;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  amount;
    logic [7:0]  floor_value;
  } cmd_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] average_out;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD_A,
    ST_MOD_B,
    ST_MOD_OFS,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_ROT,
    ST_ROT_MOD,
    ST_SWEEP,
    ST_DIV,
    ST_OUT,
    ST_CLEAR
  } state_e;

endpackage
`default_nettype wire

### rtl/core/lpbe_cmd_if.sv
`default_nettype none
interface lpbe_cmd_if
  import lpbe_pkg::*;
();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/lpbe_res_if.sv
`default_nettype none
interface lpbe_res_if
  import lpbe_pkg::*;
();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/lpbe_queue.sv
`default_nettype none
// Small command queue between the front and the back end.
module lpbe_queue
  import lpbe_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  wire  pop_i,
  output cmd_t pop_data_o,
  output logic empty_o
);
  cmd_t       mem_q [QueueDepth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'(QueueDepth));
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

### rtl/core/lpbe_front.sv
`default_nettype none
// Accepts command words and hands every one to the queue, the unused code included;
// the back end answers the unused code with an all-zero word and no memory access.
module lpbe_front
  import lpbe_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  lpbe_cmd_if.sink cmd_in,
  output logic  push_o,
  output cmd_t  push_data_o,
  input  wire   full_i
);
  logic unused_clk;
  assign unused_clk = clk_i ^ rst_ni;

  assign cmd_in.ready = ~full_i;
  assign push_o       = cmd_in.valid & ~full_i;

  always_comb begin
    push_data_o = cmd_in.data;
    if (kind_e'(cmd_in.data.kind) == KIND_NONE) begin
      push_data_o.kind = KIND_NONE;
    end
  end
endmodule
`default_nettype wire

### rtl/core/lpbe_back.sv
`default_nettype none
// Executes one command at a time against the pixel memory.
module lpbe_back
  import lpbe_pkg::*;
#(
  parameter int unsigned MaxPixels = MaxPixelsDefault
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   cfg_we_i,
  input  wire [CountWidth-1:0] cfg_wdata_i,
  input  wire   empty_i,
  input  cmd_t  cmd_i,
  output logic  pop_o,
  lpbe_res_if.source res_out
);
  localparam int unsigned Entries = 3 * MaxPixels;
  localparam int unsigned AW = $clog2(Entries + 1);
  localparam int unsigned PW = $clog2(MaxPixels + 1);
  localparam int unsigned SW = AW + 8;

  logic [7:0] mem_q [Entries];

  state_e st_q, st_d;
  cmd_t   cmd_q;
  logic [CountWidth-1:0] count_q;
  logic [PW-1:0] ofs_q;
  logic [PW-1:0] n;
  logic [16:0]   rem_q;
  logic [PW-1:0] ea_q, eb_q;
  logic [AW-1:0] idx_q, total;
  logic [1:0]    ph_q, ch_q;
  logic [7:0]    rd_q, cp_q [3];
  logic [SW-1:0] sum_q, quo_q;
  logic          out_valid_q;
  res_t          out_q, res_q;
  logic          copy_gather_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [7:0]    wr_val, col, nv;
  logic [15:0]   prod;

  always_comb begin
    if (count_q == '0) n = PW'(1);
    else if (32'(count_q) > MaxPixels) n = PW'(MaxPixels);
    else n = PW'(count_q);
  end
  assign total = AW'(3 * 32'(n));

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
    if (wr_en) mem_q[wr_addr] <= wr_val;
  end

  always_comb begin
    unique case (ph_q)
      2'd0: col = cmd_q.red;
      2'd1: col = cmd_q.green;
      default: col = cmd_q.blue;
    endcase
  end

  assign prod = rd_q * cmd_q.amount;

  // New byte for per-pixel and sweep commands, from the byte just read.
  always_comb begin
    nv = rd_q;
    unique case (kind_e'(cmd_q.kind))
      KIND_SET, KIND_FILL: nv = col;
      KIND_BLEND: nv = 8'(({1'b0, rd_q} + {1'b0, col}) >> 1);
      KIND_MAX, KIND_FILL_MAX: nv = (rd_q < col) ? col : rd_q;
      KIND_ADD: nv = ({1'b0, rd_q} + {1'b0, col} > 9'd255) ? 8'd255 : rd_q + col;
      KIND_FADE_SUB: begin
        if (rd_q <= cmd_q.floor_value) nv = rd_q;
        else if ({1'b0, rd_q} <= {1'b0, cmd_q.floor_value} + {1'b0, cmd_q.amount})
          nv = cmd_q.floor_value;
        else nv = rd_q - cmd_q.amount;
      end
      KIND_FADE_MUL: begin
        if (rd_q <= cmd_q.floor_value) nv = rd_q;
        else if (prod[15:8] <= cmd_q.floor_value) nv = cmd_q.floor_value;
        else nv = prod[15:8];
      end
      KIND_COPY: nv = cp_q[ph_q];
      KIND_SHIFT_UP, KIND_SHIFT_DOWN: nv = 8'd0;
      default: nv = rd_q;
    endcase
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLEAR: if (idx_q == AW'(Entries - 1)) st_d = ST_IDLE;
      ST_IDLE: if (!empty_i) st_d = ST_MOD_OFS;
      ST_MOD_OFS: if (ofs_q < n) begin
        priority case (kind_e'(cmd_q.kind))
          KIND_ROT_UP, KIND_ROT_DOWN, KIND_SHIFT_UP, KIND_SHIFT_DOWN: st_d = ST_ROT;
          KIND_FADE_SUB, KIND_FADE_MUL, KIND_FILL, KIND_FILL_MAX, KIND_AVERAGE:
            st_d = ST_SWEEP;
          KIND_NONE: st_d = ST_OUT;
          default: st_d = ST_MOD_A;
        endcase
      end
      ST_MOD_A: if (rem_q < 17'(n)) st_d =
          (kind_e'(cmd_q.kind) == KIND_COPY) ? ST_MOD_B : ST_PIX_RD;
      ST_MOD_B: if (rem_q < 17'(n)) st_d = ST_PIX_RD;
      ST_ROT: st_d = ST_ROT_MOD;
      ST_ROT_MOD: if (rem_q < 17'(n)) st_d = ST_PIX_RD;
      ST_PIX_RD: st_d = ST_PIX_WR;
      ST_PIX_WR: begin
        if (ph_q == 2'd2 && !copy_gather_q) st_d = ST_OUT;
        else st_d = ST_PIX_RD;
      end
      ST_SWEEP: if (idx_q == total - AW'(1) && ch_q == 2'd1)
        st_d = (kind_e'(cmd_q.kind) == KIND_AVERAGE) ? ST_DIV : ST_OUT;
      ST_DIV: if (quo_q == sum_q) st_d = ST_OUT;
      ST_OUT: if (!out_valid_q) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  logic wb_phase;
  assign wb_phase = (ch_q == 2'd1);

  always_comb begin
    rd_addr = idx_q;
    wr_addr = idx_q;
    wr_en   = 1'b0;
    wr_val  = nv;
    pop_o   = (st_q == ST_IDLE) && !empty_i;
    unique case (st_q)
      ST_CLEAR: begin
        wr_en = 1'b1;
        wr_val = 8'd0;
      end
      ST_PIX_RD, ST_PIX_WR: begin
        rd_addr = AW'(3 * 32'(ea_q)) + AW'(ph_q);
        wr_addr = AW'(3 * 32'(eb_q)) + AW'(ph_q);
        wr_en = (st_q == ST_PIX_WR) && wb_phase &&
                kind_e'(cmd_q.kind) != KIND_READ && kind_e'(cmd_q.kind) != KIND_ROT_UP &&
                kind_e'(cmd_q.kind) != KIND_ROT_DOWN && !copy_gather_q;
      end
      ST_SWEEP: begin
        wr_en = wb_phase && kind_e'(cmd_q.kind) != KIND_AVERAGE;
      end
      default: ;
    endcase
  end

  // Per-pixel: phases 0..2 over channels, each a read state then a write state
  // (ch_q 0 = read issued, 1 = data in rd_q). Copy gathers all three first.
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE) cmd_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR;
      count_q <= CountWidth'(1024);
      ofs_q <= '0;
      idx_q <= '0;
      ph_q <= '0;
      ch_q <= '0;
      rem_q <= '0;
      ea_q <= '0;
      eb_q <= '0;
      sum_q <= '0;
      quo_q <= '0;
      out_valid_q <= 1'b0;
      out_q <= '0;
      res_q <= '0;
      copy_gather_q <= 1'b0;
      cp_q[0] <= '0;
      cp_q[1] <= '0;
      cp_q[2] <= '0;
    end else begin
      if (cfg_we_i) count_q <= cfg_wdata_i;
      if (out_valid_q && res_out.ready) out_valid_q <= 1'b0;
      unique case (st_q)
        ST_CLEAR: idx_q <= idx_q + AW'(1);
        ST_IDLE: begin
          rem_q <= {{(17-PW){1'b0}}, ofs_q};
          out_q <= '0;
          ph_q <= '0;
          ch_q <= '0;
          idx_q <= '0;
          sum_q <= '0;
          quo_q <= '0;
          copy_gather_q <= 1'b0;
        end
        ST_MOD_OFS: begin
          if (ofs_q >= n) ofs_q <= ofs_q - n;
          else rem_q <= 17'(cmd_q.pixel) + 17'(ofs_q);
        end
        ST_MOD_A: begin
          if (rem_q >= 17'(n)) rem_q <= rem_q - 17'(n);
          else begin
            ea_q <= PW'(rem_q);
            eb_q <= PW'(rem_q);
            rem_q <= 17'(cmd_q.second_pixel) + 17'(ofs_q);
            copy_gather_q <= (kind_e'(cmd_q.kind) == KIND_COPY);
          end
        end
        ST_MOD_B: begin
          if (rem_q >= 17'(n)) rem_q <= rem_q - 17'(n);
          else eb_q <= PW'(rem_q);
        end
        ST_ROT: begin
          if (kind_e'(cmd_q.kind) == KIND_ROT_UP || kind_e'(cmd_q.kind) == KIND_SHIFT_UP) begin
            ofs_q <= (ofs_q == '0) ? n - PW'(1) : ofs_q - PW'(1);
            rem_q <= (ofs_q == '0) ? 17'(n - PW'(1)) : 17'(ofs_q - PW'(1));
          end else begin
            ofs_q <= (ofs_q == n - PW'(1)) ? '0 : ofs_q + PW'(1);
            rem_q <= (ofs_q == n - PW'(1)) ? 17'(n - PW'(1)) : 17'(ofs_q) + 17'(n);
          end
        end
        ST_ROT_MOD: begin
          if (rem_q >= 17'(n)) rem_q <= rem_q - 17'(n);
          else begin
            ea_q <= PW'(rem_q);
            eb_q <= PW'(rem_q);
          end
        end
        ST_PIX_RD: ch_q <= 2'd1;
        ST_PIX_WR: begin
          if (kind_e'(cmd_q.kind) == KIND_READ) begin
            unique case (ph_q)
              2'd0: out_q.red_out <= rd_q;
              2'd1: out_q.green_out <= rd_q;
              default: out_q.blue_out <= rd_q;
            endcase
          end
          if (copy_gather_q) cp_q[ph_q] <= rd_q;
          if (ph_q == 2'd2 && copy_gather_q) begin
            copy_gather_q <= 1'b0;
            ph_q <= '0;
            ch_q <= '0;
          end else begin
            ch_q <= '0;
            if (ph_q != 2'd2) ph_q <= ph_q + 2'd1;
          end
        end
        ST_SWEEP: begin
          // Read entry idx, then write it back in the next cycle (average only adds it to the sum).
          if (ch_q == 2'd0) begin
            ch_q <= 2'd1;
          end else begin
            if (kind_e'(cmd_q.kind) == KIND_AVERAGE)
              sum_q <= sum_q + SW'(rd_q);
            if (idx_q != total - AW'(1)) begin
              idx_q <= idx_q + AW'(1);
              ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
              ch_q <= 2'd0;
            end
          end
        end
        ST_DIV: begin
          // Repeated subtraction: quotient is at most 255.
          if (quo_q != sum_q) begin
            if (sum_q >= SW'(total)) begin
              sum_q <= sum_q - SW'(total);
              out_q.average_out <= out_q.average_out + 8'd1;
            end else quo_q <= sum_q;
          end
        end
        ST_OUT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            res_q <= out_q;
          end
        end
        default: ;
      endcase
      st_q <= st_d;
    end
  end

  assign res_out.valid = out_valid_q;
  assign res_out.data  = res_q;
endmodule
`default_nettype wire

### rtl/core/led_pixel_buffer_engine.sv
`default_nettype none
// Channel   Direction  Word
// cmd_in    in         kind, pixel, second_pixel, red, green, blue, amount, floor_value
// res_out   out        red_out, green_out, blue_out, average_out
// cfg       in         pixel_count, written with cfg_we_i
// A per-pixel command reduces the offset and the index by repeated subtraction of the
// pixel count before it touches memory; copy reads the source before writing.
// Whole-buffer commands sweep 3n entries, each read and, but for the mean, written back
// through one read and one write port; the mean then divides by repeated subtraction.
// After reset all 3*MaxPixels memory entries are cleared before the first command.
// Commands queue two deep while the back end works or its result waits.
module led_pixel_buffer_engine
  import lpbe_pkg::*;
#(
  parameter int unsigned MaxPixels = MaxPixelsDefault
) (
  input  wire clk_i,
  input  wire rst_ni,
  input  wire cfg_we_i,
  input  wire [CountWidth-1:0] cfg_wdata_i,
  lpbe_cmd_if.sink   cmd_in,
  lpbe_res_if.source res_out
);
  logic push, full, pop, empty;
  cmd_t push_data, pop_data;

  lpbe_front u_front (
    .clk_i, .rst_ni, .cmd_in,
    .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  lpbe_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .pop_data_o(pop_data), .empty_o(empty)
  );

  lpbe_back #(.MaxPixels(MaxPixels)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .empty_i(empty), .cmd_i(pop_data), .pop_o(pop), .res_out
  );
endmodule
`default_nettype wire

### test/led_pixel_buffer_engine_checker.sv
`timescale 1ns / 1ps
module led_pixel_buffer_engine_checker
  import lpbe_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CountWidth-1:0] cfg_wdata_i,
  input  wire                  cmd_valid_i,
  input  wire                  cmd_ready_i,
  input  cmd_t                 cmd_i,
  input  wire                  res_valid_i,
  input  wire                  res_ready_i,
  input  res_t                 res_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  logic [7:0]            shadow_bytes [3*MaxPixelsDefault];
  logic [9:0]            shadow_offset;
  logic [CountWidth-1:0] shadow_count;
  res_t                  awaited_words [$];

  assign pending_o = awaited_words.size();

  function automatic int unsigned live_pixels();
    if (shadow_count == 0) return 1;
    if (shadow_count > MaxPixelsDefault) return MaxPixelsDefault;
    return 32'(shadow_count);
  endfunction

  function automatic int unsigned slot_of(int unsigned logical, int unsigned n);
    return 3 * ((logical + 32'(shadow_offset)) % n);
  endfunction

  function automatic void turn_offset(bit up, int unsigned n);
    int unsigned o;
    o = 32'(shadow_offset) % n;
    if (up) o = (o == 0) ? n - 1 : o - 1;
    else o = (o == n - 1) ? 0 : o + 1;
    shadow_offset = 10'(o);
  endfunction

  // Applies one command to the shadow store and returns the word it should produce.
  function automatic res_t apply_command(cmd_t c);
    res_t          r;
    int unsigned   n, e, e2, v, sum;
    logic [7:0]    col [3];
    kind_e         k;
    r = '0;
    n = live_pixels();
    col[0] = c.red; col[1] = c.green; col[2] = c.blue;
    k = kind_e'(c.kind);
    e = slot_of(32'(c.pixel), n);
    case (k)
      KIND_SET: for (int i = 0; i < 3; i++) shadow_bytes[e+i] = col[i];
      KIND_BLEND:
        for (int i = 0; i < 3; i++)
          shadow_bytes[e+i] = 8'((9'(shadow_bytes[e+i]) + 9'(col[i])) >> 1);
      KIND_MAX:
        for (int i = 0; i < 3; i++)
          if (shadow_bytes[e+i] < col[i]) shadow_bytes[e+i] = col[i];
      KIND_ADD:
        for (int i = 0; i < 3; i++) begin
          v = 32'(shadow_bytes[e+i]) + 32'(col[i]);
          shadow_bytes[e+i] = (v > 255) ? 8'd255 : v[7:0];
        end
      KIND_READ: begin
        r.red_out = shadow_bytes[e];
        r.green_out = shadow_bytes[e+1];
        r.blue_out = shadow_bytes[e+2];
      end
      KIND_COPY: begin
        e2 = slot_of(32'(c.second_pixel), n);
        for (int i = 0; i < 3; i++) shadow_bytes[e2+i] = shadow_bytes[e+i];
      end
      KIND_ROT_UP, KIND_ROT_DOWN: turn_offset(k == KIND_ROT_UP, n);
      KIND_SHIFT_UP, KIND_SHIFT_DOWN: begin
        turn_offset(k == KIND_SHIFT_UP, n);
        e2 = slot_of((k == KIND_SHIFT_UP) ? 0 : n - 1, n);
        for (int i = 0; i < 3; i++) shadow_bytes[e2+i] = '0;
      end
      KIND_FADE_SUB:
        for (int i = 0; i < 3 * n; i++) begin
          v = 32'(shadow_bytes[i]);
          if (v > c.floor_value) begin
            if (v <= 32'(c.floor_value) + 32'(c.amount)) shadow_bytes[i] = c.floor_value;
            else shadow_bytes[i] = 8'(v - 32'(c.amount));
          end
        end
      KIND_FADE_MUL:
        for (int i = 0; i < 3 * n; i++) begin
          v = 32'(shadow_bytes[i]);
          if (v > c.floor_value) begin
            v = (v * 32'(c.amount)) >> 8;
            shadow_bytes[i] = (v <= c.floor_value) ? c.floor_value : v[7:0];
          end
        end
      KIND_FILL: for (int i = 0; i < 3 * n; i++) shadow_bytes[i] = col[i%3];
      KIND_FILL_MAX:
        for (int i = 0; i < 3 * n; i++)
          if (shadow_bytes[i] < col[i%3]) shadow_bytes[i] = col[i%3];
      KIND_AVERAGE: begin
        sum = 0;
        for (int i = 0; i < 3 * n; i++) sum += 32'(shadow_bytes[i]);
        sum = sum / (3 * n);
        r.average_out = (sum > 255) ? 8'd255 : sum[7:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
      shadow_offset = '0;
      shadow_count = CountWidth'(MaxPixelsDefault);
      awaited_words.delete();
      fail_count_o = 0;
    end else begin
      // Results leave before this edge's command is counted, so pop first.
      if (res_valid_i && res_ready_i) begin
        if (awaited_words.size() == 0) begin
          $display("%0t: unexpected word %h", $time, res_i);
          fail_count_o++;
        end else begin
          want = awaited_words.pop_front();
          if (want.red_out !== res_i.red_out || want.green_out !== res_i.green_out ||
              want.blue_out !== res_i.blue_out || want.average_out !== res_i.average_out) begin
            $display("%0t: expected %h actual %h", $time, want, res_i);
            fail_count_o++;
          end
        end
      end
      if (cmd_valid_i && cmd_ready_i) awaited_words.push_back(apply_command(cmd_i));
      if (cfg_we_i) shadow_count = cfg_wdata_i;
    end
  end

endmodule

### test/led_pixel_buffer_engine_tb.sv
`timescale 1ns / 1ps
module led_pixel_buffer_engine_tb;
  import lpbe_pkg::*;

  // A per-pixel command on a one-pixel strip with a 16-bit index subtracts the pixel
  // count from the index one step at a time, so the limit sits well above that run.
  localparam int unsigned StallLimit = 400000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CountWidth-1:0] cfg_wdata_i = '0;
  int                    fail_count, pending, idle_cycles;
  bit                    hold_off = 1'b0;

  lpbe_cmd_if cmd_in ();
  lpbe_res_if res_out ();

  always #2 clk_i = ~clk_i;

  led_pixel_buffer_engine dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .cmd_in(cmd_in.sink), .res_out(res_out.source)
  );

  led_pixel_buffer_engine_checker checker_inst (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .cmd_valid_i(cmd_in.valid), .cmd_ready_i(cmd_in.ready), .cmd_i(cmd_in.data),
    .res_valid_i(res_out.valid), .res_ready_i(res_out.ready), .res_i(res_out.data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    cmd_in.valid = 1'b0;
    cmd_in.data = '0;
    res_out.ready = 1'b0;
  end

  // Receiver: random stalls per word, plus one long hold-off on request.
  always begin
    int unsigned gap;
    @(posedge clk_i);
    if (rst_ni) begin
      if (hold_off) begin
        res_out.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        res_out.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_out.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_out.valid && res_out.ready));
      res_out.ready <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_in.valid && cmd_in.ready) || (res_out.valid && res_out.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("led_pixel_buffer_engine_tb: errors");
      $finish;
    end
  end

  // Leaves valid high after the word is taken; the next call replaces the word or drops valid, or the caller drops it.
  task automatic send_word(cmd_t c, bit no_gaps);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      cmd_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_in.valid <= 1'b1;
    cmd_in.data <= c;
    do @(posedge clk_i); while (!cmd_in.ready);
  endtask

  task automatic send_kind(kind_e k, int unsigned p, int unsigned q, logic [23:0] rgb,
                           logic [7:0] amt, logic [7:0] flo);
    cmd_t c;
    c.kind = k; c.pixel = 16'(p); c.second_pixel = 16'(q);
    {c.red, c.green, c.blue} = rgb;
    c.amount = amt; c.floor_value = flo;
    send_word(c, 1'b0);
  endtask

  task automatic drain_and_set(logic [CountWidth-1:0] count);
    cmd_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic cmd_t random_word(int unsigned count);
    cmd_t        c;
    int unsigned roll, span;
    c = cmd_t'(76'({$urandom, $urandom, $urandom}));
    span = (count == 0) ? 1 : count;
    roll = $urandom_range(0, 99);
    // Whole-buffer sweeps are slow, so keep them rare and mostly per-pixel traffic.
    if (roll < 70) c.kind = 4'($urandom_range(KIND_SET, KIND_COPY));
    else if (roll < 88) c.kind = 4'($urandom_range(KIND_ROT_UP, KIND_SHIFT_DOWN));
    else if (roll < 98) c.kind = 4'($urandom_range(KIND_FADE_SUB, KIND_AVERAGE));
    else c.kind = KIND_NONE;
    if ($urandom_range(0, 3) != 0) begin
      c.pixel = 16'($urandom_range(0, 2 * span));
      c.second_pixel = 16'($urandom_range(0, 2 * span));
    end
    return c;
  endfunction

  initial begin
    int unsigned counts [6];
    counts = '{16, 1, 0, 7, 1024, 2047};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed pass on the full strip, which also exercises a 16-bit index.
    send_kind(KIND_SET, 0, 0, 24'hFF00FF, 0, 0);
    send_kind(KIND_SET, 16'hFFFF, 0, 24'h80FF01, 0, 0);
    send_kind(KIND_READ, 16'hFFFF, 0, 0, 0, 0);
    send_kind(KIND_BLEND, 0, 0, 24'hFFFFFF, 0, 0);
    send_kind(KIND_MAX, 0, 0, 24'h10FF20, 0, 0);
    send_kind(KIND_ADD, 0, 0, 24'hFF0101, 0, 0);
    send_kind(KIND_READ, 0, 0, 0, 0, 0);
    send_kind(KIND_COPY, 0, 1023, 0, 0, 0);
    send_kind(KIND_READ, 1023, 0, 0, 0, 0);
    send_kind(KIND_ROT_UP, 0, 0, 0, 0, 0);
    send_kind(KIND_ROT_DOWN, 0, 0, 0, 0, 0);
    send_kind(KIND_SHIFT_UP, 0, 0, 0, 0, 0);
    send_kind(KIND_SHIFT_DOWN, 0, 0, 0, 0, 0);
    send_kind(KIND_READ, 1, 0, 0, 0, 0);
    send_kind(KIND_AVERAGE, 0, 0, 0, 0, 0);
    send_kind(KIND_FILL, 0, 0, 24'hFFFFFF, 0, 0);
    send_kind(KIND_AVERAGE, 0, 0, 0, 0, 0);
    send_kind(KIND_FADE_SUB, 0, 0, 0, 8'd255, 8'd0);
    send_kind(KIND_FILL_MAX, 0, 0, 24'hC08040, 0, 0);
    send_kind(KIND_FADE_SUB, 0, 0, 0, 8'd50, 8'd100);
    send_kind(KIND_FADE_MUL, 0, 0, 0, 8'd255, 8'd0);
    send_kind(KIND_FADE_MUL, 0, 0, 0, 8'd128, 8'd70);
    send_kind(KIND_READ, 5, 0, 0, 0, 0);
    send_kind(KIND_NONE, 0, 0, 24'hFFFFFF, 8'd255, 8'd255);
    // Random phases over several strip lengths, including zero and over range.
    foreach (counts[ci]) begin
      drain_and_set(CountWidth'(counts[ci]));
      if (ci == 0) hold_off = 1'b1;
      for (int i = 0; i < 300; i++) begin
        cmd_t c;
        c = random_word(counts[ci]);
        if (counts[ci] >= 1024 && c.kind inside {[KIND_FADE_SUB:KIND_AVERAGE]} &&
            $urandom_range(0, 3) != 0) c.kind = KIND_READ;
        send_word(c, (i / 50) % 3 == 2);
      end
    end
    cmd_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("led_pixel_buffer_engine_tb: clean");
    else $display("led_pixel_buffer_engine_tb: errors");
    $finish;
  end

endmodule
